// ----- sv/spl_pkg.sv -----
// Shared types and codes for the step potential lookup block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package spl_pkg;

  // Operation carried in the tuser field of an input item.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PREV,
    ST_PROBE,
    ST_CMP,
    ST_OUT
  } st_t;

  // Read and write strobes for one memory port.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

// ----- sv/spl_step_ram.sv -----
// Step entry store: squared thresholds and energies, one port, registered read.
// Depends on spl_pkg for the port command struct.
`timescale 1ns / 1ps

module spl_step_ram
  import spl_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk,
  input  mem_cmd_t      cmd,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wr_thr,
  input  logic [31:0]   wr_energy,
  output logic [31:0]   rd_thr,
  output logic [31:0]   rd_energy
);

  localparam int DEPTH = 1 << AW;

  logic [31:0] thr_mem    [DEPTH];
  logic [31:0] energy_mem [DEPTH];

  // Single port: a write and a read never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      thr_mem[addr]    <= wr_thr;
      energy_mem[addr] <= wr_energy;
    end
    if (cmd.rd) begin
      rd_thr    <= thr_mem[addr];
      rd_energy <= energy_mem[addr];
    end
  end

endmodule

// ----- sv/spl_count_ram.sv -----
// Per-pair entry counts in a memory, with one valid bit per pair so that
// reset empties every table at once. Depends on spl_pkg.
`timescale 1ns / 1ps

module spl_count_ram
  import spl_pkg::*;
#(
  parameter int PAIRS = 16,
  parameter int PW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_cmd_t      cmd,
  input  logic [PW-1:0] addr,
  input  logic [CW-1:0] wr_data,
  output logic [CW-1:0] rd_data
);

  logic [CW-1:0]    cnt_mem [PAIRS];
  logic [PAIRS-1:0] valid_r;
  logic             rd_valid_r;
  logic [CW-1:0]    rd_mem_r;

  // Valid bits: cleared by reset, set by the first write to a pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr) begin
      valid_r[addr] <= 1'b1;
    end
  end

  // Count memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      cnt_mem[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_mem_r   <= cnt_mem[addr];
      rd_valid_r <= valid_r[addr];
    end
  end

  // A pair never written reads as an empty table.
  assign rd_data = rd_valid_r ? rd_mem_r : '0;

endmodule

// ----- sv/spl_ctrl.sv -----
// Sequencer with the shared compare unit: decodes an item, checks writes,
// runs the binary search and holds the result register. Depends on spl_pkg.
`timescale 1ns / 1ps

module spl_ctrl
  import spl_pkg::*;
#(
  parameter int NUM_TYPES = 4,
  parameter int MAX_STEPS = 16,
  parameter int PW        = 4,
  parameter int SW        = 4,
  parameter int CW        = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  // item side
  input  logic             in_valid,
  output logic             in_ready,
  input  mode_t            in_mode,
  input  logic [1:0]       in_first_type,
  input  logic [1:0]       in_second_type,
  input  logic [3:0]       in_entry_index,
  input  logic [15:0]      in_step_radius,
  input  logic [31:0]      in_step_energy,
  input  logic [31:0]      in_distance_squared,
  // result side
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_pair_energy,
  output logic             out_status,
  // count memory port
  output mem_cmd_t         cnt_cmd,
  output logic [PW-1:0]    cnt_addr,
  output logic [CW-1:0]    cnt_wdata,
  input  logic [CW-1:0]    cnt_rdata,
  // step memory port
  output mem_cmd_t         step_cmd,
  output logic [PW+SW-1:0] step_addr,
  output logic [31:0]      step_wthr,
  output logic [31:0]      step_wenergy,
  input  logic [31:0]      step_rthr,
  input  logic [31:0]      step_renergy
);

  st_t state_r, state_nxt;

  // Latched item.
  mode_t         mode_r;
  logic          ok_r;
  logic [PW-1:0] slot_r;
  logic [3:0]    idx_r;
  logic [15:0]   radius_r;
  logic [31:0]   energy_r;
  logic [31:0]   dsq_r;
  logic [31:0]   rsq_r;

  // Search and result state.
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [CW-1:0] right_r, right_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [31:0]   hit_r, hit_nxt;
  logic          status_r, status_nxt;
  logic          out_valid_r;
  logic [31:0]   out_energy_r;
  logic          out_status_r;

  // Combinational helpers.
  logic          accept;
  logic [1:0]    lo_type, hi_type;
  logic          in_ok;
  logic [PW-1:0] in_slot;
  logic [31:0]   sq_full;
  logic          wr_reject;
  logic          wr_go;
  logic [31:0]   cmp_a, cmp_b;
  logic          cmp_le;
  logic [CW:0]   mid_sum;
  logic          out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Unordered pair: the smaller type selects the row.
  always_comb begin
    lo_type = (in_first_type < in_second_type) ? in_first_type : in_second_type;
    hi_type = (in_first_type < in_second_type) ? in_second_type : in_first_type;
    in_ok   = 32'(hi_type) < NUM_TYPES;
    in_slot = PW'(32'(lo_type) * NUM_TYPES + 32'(hi_type));
  end

  // Squarer: UQ8.8 squared is exact in UQ16.16.
  assign sq_full = radius_r * radius_r;

  // Write checks against the freshly read count.
  always_comb begin
    wr_reject = (32'(idx_r) >= MAX_STEPS) ||
                ((idx_r != 4'd0) && (32'(idx_r) > 32'(cnt_rdata)));
    wr_go     = (mode_r == MODE_WRITE) && ok_r && !wr_reject;
  end

  // Shared compare unit: previous threshold check or search probe.
  always_comb begin
    if (state_r == ST_PREV) begin
      cmp_a = rsq_r;
      cmp_b = step_rthr;
    end else begin
      cmp_a = step_rthr;
      cmp_b = dsq_r;
    end
    cmp_le = cmp_a <= cmp_b;
  end

  assign mid_sum = {1'b0, left_r} + {1'b0, right_r};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (wr_go) begin
          state_nxt = ST_PREV;
        end else if (mode_r == MODE_QUERY && ok_r && cnt_rdata != '0) begin
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_PREV:  state_nxt = ST_OUT;
      ST_PROBE: state_nxt = ST_CMP;
      ST_CMP: begin
        if (left_nxt < right_nxt) begin
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory commands and working register updates.
  always_comb begin
    cnt_cmd      = '0;
    cnt_addr     = slot_r;
    cnt_wdata    = '0;
    step_cmd     = '0;
    step_addr    = {slot_r, SW'(idx_r)};
    step_wthr    = rsq_r;
    step_wenergy = energy_r;
    n_nxt        = n_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    mid_nxt      = mid_r;
    hit_nxt      = hit_r;
    status_nxt   = status_r;
    in_ready     = state_r == ST_IDLE;
    case (state_r)
      ST_IDLE: begin
        // The count is read while the item is taken.
        cnt_addr   = in_slot;
        cnt_cmd.rd = accept;
      end
      ST_COUNT: begin
        n_nxt      = cnt_rdata;
        left_nxt   = '0;
        right_nxt  = cnt_rdata;
        status_nxt = STATUS_OK;
        if (mode_r == MODE_CLEAR && ok_r) begin
          cnt_cmd.wr = 1'b1;
        end
        if (mode_r == MODE_WRITE && ok_r && wr_reject) begin
          status_nxt = STATUS_REJECT;
        end
        // Fetch the previous threshold for the increasing-radius check.
        if (wr_go && idx_r != 4'd0) begin
          step_cmd.rd = 1'b1;
          step_addr   = {slot_r, SW'(idx_r - 4'd1)};
        end
      end
      ST_PREV: begin
        if (idx_r != 4'd0 && cmp_le) begin
          status_nxt = STATUS_REJECT;
        end else begin
          step_cmd.wr = 1'b1;
          cnt_cmd.wr  = 1'b1;
          cnt_wdata   = CW'(5'(idx_r) + 5'd1);
        end
      end
      ST_PROBE: begin
        mid_nxt     = CW'(mid_sum >> 1);
        step_cmd.rd = 1'b1;
        step_addr   = {slot_r, SW'(mid_sum >> 1)};
      end
      ST_CMP: begin
        if (cmp_le) begin
          left_nxt = mid_r + 1'b1;
        end else begin
          right_nxt = mid_r;
          hit_nxt   = step_renergy;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      ok_r     <= in_ok;
      slot_r   <= in_slot;
      idx_r    <= in_entry_index;
      radius_r <= in_step_radius;
      energy_r <= in_step_energy;
      dsq_r    <= in_distance_squared;
    end
    if (state_r == ST_COUNT) begin
      rsq_r <= sq_full;
    end
    n_r      <= n_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    mid_r    <= mid_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    // The search ends with right at the first threshold above the distance.
    if (state_r == ST_OUT && out_free) begin
      out_status_r <= (mode_r == MODE_WRITE) ? status_r : STATUS_OK;
      out_energy_r <= (mode_r == MODE_QUERY && ok_r && right_r < n_r) ? hit_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pair_energy = out_energy_r;
  assign out_status      = out_status_r;

  // A probe is only issued inside a non-empty, in-range interval.
  a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PROBE |-> (left_r < right_r) && (right_r <= n_r))
    else $error("search interval out of range at probe");

  // The compared entry lies below the table length.
  a_cmp_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> mid_r < n_r)
    else $error("probed entry beyond table length");

  // Each compare follows its own probe read.
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> $past(state_r) == ST_PROBE)
    else $error("compare without a preceding probe");

  // An entry is stored only together with the new count of its pair.
  a_store_with_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_cmd.wr |-> cnt_cmd.wr && (cnt_wdata != '0))
    else $error("entry written without count update");

  // A finished item loads the result register and frees the sequencer.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("result not loaded on completion");

endmodule

// ----- sv/step_potential_lookup_top.sv -----
// Top level of the step potential lookup: stream ports, field unpacking and
// the sequencer with its two memories. Depends on spl_pkg and all spl_ modules.
`timescale 1ns / 1ps

//  Channel | Direction | Ports                          | Contents
//  in_     | slave     | tvalid tready tdata[87:0] tuser | one operation item
//  out_    | master    | tvalid tready tdata[39:0]       | one result item per input item
//
// Steps per item: clear, unused modes, a write rejected on its index and a
// query of an empty or out-of-range pair pass from COUNT to OUT. A write that
// passes the index checks runs PREV in between, whether it is stored or refused
// for a radius that does not grow. A query of a non-empty table runs p PROBE and
// CMP pairs in between, p being the probes of the binary search (at most 5 with
// 16 entries), each one registered read of the step memory and one compare.
// Reset clears the sequencer and one valid bit per pair; all tables are empty
// at once and no clearing pass is run. A result waits in the output register
// while the next item is taken; the sequencer holds its last state only if
// that register is still full when the next result is ready.

module step_potential_lookup_top
  import spl_pkg::*;
#(
  parameter int NUM_TYPES = 4,
  parameter int MAX_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_type[1:0], second_type[3:2], entry_index[7:4], step_radius[23:8],
  // step_energy[55:24], distance_squared[87:56]
  input  logic [87:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pair_energy[31:0], status[32], zero fill [39:33]
  output logic [39:0] out_tdata
);

  localparam int PAIRS = NUM_TYPES * NUM_TYPES;
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW    = $clog2(MAX_STEPS + 1);

  mem_cmd_t         cnt_cmd;
  logic [PW-1:0]    cnt_addr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_rdata;
  mem_cmd_t         step_cmd;
  logic [PW+SW-1:0] step_addr;
  logic [31:0]      step_wthr;
  logic [31:0]      step_wenergy;
  logic [31:0]      step_rthr;
  logic [31:0]      step_renergy;
  logic [31:0]      pair_energy;
  logic             status;

  // Sequencer and compare unit.
  spl_ctrl #(
    .NUM_TYPES (NUM_TYPES),
    .MAX_STEPS (MAX_STEPS),
    .PW        (PW),
    .SW        (SW),
    .CW        (CW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_tvalid),
    .in_ready            (in_tready),
    .in_mode             (mode_t'(in_tuser)),
    .in_first_type       (in_tdata[1:0]),
    .in_second_type      (in_tdata[3:2]),
    .in_entry_index      (in_tdata[7:4]),
    .in_step_radius      (in_tdata[23:8]),
    .in_step_energy      (in_tdata[55:24]),
    .in_distance_squared (in_tdata[87:56]),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_pair_energy     (pair_energy),
    .out_status          (status),
    .cnt_cmd             (cnt_cmd),
    .cnt_addr            (cnt_addr),
    .cnt_wdata           (cnt_wdata),
    .cnt_rdata           (cnt_rdata),
    .step_cmd            (step_cmd),
    .step_addr           (step_addr),
    .step_wthr           (step_wthr),
    .step_wenergy        (step_wenergy),
    .step_rthr           (step_rthr),
    .step_renergy        (step_renergy)
  );

  // Per-pair entry counts.
  spl_count_ram #(
    .PAIRS (PAIRS),
    .PW    (PW),
    .CW    (CW)
  ) u_count_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cnt_cmd),
    .addr    (cnt_addr),
    .wr_data (cnt_wdata),
    .rd_data (cnt_rdata)
  );

  // Step entries, addressed by pair and entry index.
  spl_step_ram #(
    .AW (PW + SW)
  ) u_step_ram (
    .clk       (clk),
    .cmd       (step_cmd),
    .addr      (step_addr),
    .wr_thr    (step_wthr),
    .wr_energy (step_wenergy),
    .rd_thr    (step_rthr),
    .rd_energy (step_renergy)
  );

  // Result packing.
  assign out_tdata = {7'd0, status, pair_energy};

endmodule
